// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the rtl of the change-event encoder
// needs clk_i and rst_ni in the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define GCEE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication from a condition to something in the next cycle
`define GCEE_ASSERT_NEXT(label, cond, prop, msg) \
  `GCEE_ASSERT(label, (cond) |=> (prop), msg)

`endif

// ===== hw/rtl/gcee_pkg.sv =====
// types, constants and small functions of the gamepad change-event encoder
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package gcee_pkg;

  // button count, capped at the width of the button word
  localparam int NUM_BUTTONS = 16;
  localparam int BtnLimit    = (NUM_BUTTONS > 16) ? 16 : NUM_BUTTONS;

  // configuration register indexes
  localparam logic [1:0] CfgAxisDb = 2'd0;
  localparam logic [1:0] CfgTrigDb = 2'd1;

  localparam logic [15:0] AxisDbReset = 16'd800;
  localparam logic [7:0]  TrigDbReset = 8'd10;

  // event kinds
  localparam logic KindButton = 1'b0;
  localparam logic KindAxis   = 1'b1;

  // scan slots: buttons 0..15, axes, triggers, hat x, hat y
  localparam logic [4:0] SlotBtnFirstU = 5'd0;
  localparam logic [4:0] SlotBtnFirstS = 5'd4;
  localparam logic [4:0] SlotBtnLast   = 5'd15;
  localparam logic [4:0] SlotBtnEnd    = 5'(BtnLimit);
  localparam logic [4:0] SlotAx0       = 5'd16;
  localparam logic [4:0] SlotTrg0      = 5'd20;
  localparam logic [4:0] SlotHatX      = 5'd22;
  localparam logic [4:0] SlotHatY      = 5'd23;

  // event codes that are not derived from the slot
  localparam logic [4:0] CodeTrg0 = 5'd4;
  localparam logic [4:0] CodeHatX = 5'd16;

  // hat values and pov angles
  localparam logic [15:0] HatPos    = 16'h7FFF;
  localparam logic [15:0] HatNeg    = 16'h8001;
  localparam logic [15:0] PovCentre = 16'hFFFF;
  localparam logic [15:0] Pov45     = 16'd4500;
  localparam logic [15:0] Pov135    = 16'd13500;
  localparam logic [15:0] Pov225    = 16'd22500;
  localparam logic [15:0] Pov315    = 16'd31500;
  localparam logic [15:0] AxisBias  = 16'h8000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } seq_state_e;

  // request to the shared compare unit: |op_a - op_b| > thr
  typedef struct packed {
    logic [16:0] op_a;
    logic [16:0] op_b;
    logic [15:0] thr;
  } cmp_req_t;

  // level * 32767 / 255 as level * 128 + level * 127 / 255
  function automatic logic [15:0] trig_scale(logic [7:0] lv);
    logic [15:0] y;
    logic [15:0] q;
    y = {1'b0, lv, 7'b0} - {8'b0, lv};
    q = 16'((y + {8'b0, y[15:8]} + 16'd1) >> 8);
    return {1'b0, lv, 7'b0} + q;
  endfunction

  // pov angle to {hat x, hat y}
  function automatic logic [31:0] pov_to_hat(logic [15:0] pov);
    logic [15:0] hx;
    logic [15:0] hy;
    hx = '0;
    hy = '0;
    if (pov != PovCentre) begin
      if (pov >= Pov315 || pov <= Pov45) begin
        hy = HatNeg;
      end else if (pov >= Pov135 && pov <= Pov225) begin
        hy = HatPos;
      end
      if (pov >= Pov45 && pov <= Pov135) begin
        hx = HatPos;
      end else if (pov >= Pov225 && pov <= Pov315) begin
        hx = HatNeg;
      end
    end
    return {hx, hy};
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/gcee_diff_unit.sv =====
// shared absolute-difference compare unit of the change-event encoder
// depends on gcee_pkg for the request struct
`timescale 1ns / 1ps
`default_nettype none

module gcee_diff_unit import gcee_pkg::*; (
  input  cmp_req_t req_i,
  output logic     hit_o
);

  logic [17:0] diff;
  logic [16:0] mag;

  // signed 17-bit operands, 18-bit difference
  assign diff = {req_i.op_a[16], req_i.op_a} - {req_i.op_b[16], req_i.op_b};

  // magnitude fits in 17 bits unsigned
  assign mag = diff[17] ? 17'(~diff + 18'd1) : diff[16:0];

  assign hit_o = mag > {1'b0, req_i.thr};

endmodule

`default_nettype wire

// ===== hw/rtl/gamepad_change_event_encoder_top.sv =====
// top level of the gamepad change-event encoder: sample latch, scan sequencer,
// previous-value state and output register; uses gcee_pkg and gcee_diff_unit
//
//   channel | direction | handshake                   | payload
//   in      | sink      | in_valid_i / in_stall_o     | one gamepad sample
//   out     | source    | out_valid_o / out_stall_i   | one change event
//   cfg     | sink      | cfg_we_i                    | cfg_idx_i, cfg_wdata_i
//
// a sample is scanned one slot a cycle through one shared compare unit, except
// that the scan waits while a new event meets a held one and the output is
// stalled: 20 slots for a signed-style sample, 24 for an unsigned-style one,
// then the flush state releases the final event before the next request is
// taken. reset sets the previous values to their idle values and the deadbands
// to 800 and 10; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module gamepad_change_event_encoder_top import gcee_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  // sample requests
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [15:0] button_bits_i,
  input  logic [15:0] stick_lx_i,
  input  logic [15:0] stick_ly_i,
  input  logic [15:0] stick_rx_i,
  input  logic [15:0] stick_ry_i,
  input  logic [7:0]  trig_left_i,
  input  logic [7:0]  trig_right_i,
  input  logic [15:0] pov_angle_i,
  // events
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        event_kind_o,
  output logic [4:0]  event_code_o,
  output logic signed [15:0] event_value_o,
  output logic        last_event_o
);

  // configuration registers
  logic [15:0] axis_db_q;
  logic [7:0]  trig_db_q;

  // latched sample
  logic        smp_mode_q;
  logic [15:0] smp_btn_q;
  logic [15:0] smp_axis_q [4];
  logic [7:0]  smp_trig_q [2];
  logic [15:0] smp_pov_q;

  // previous values
  logic [15:0] prev_sbtn_q;
  logic [15:0] prev_saxes_q [4];
  logic [7:0]  prev_trig_q [2];
  logic [15:0] prev_hat_q [2];
  logic [15:0] prev_ubtn_q;
  logic [15:0] prev_uaxes_q [4];
  logic [15:0] prev_pov_q;
  logic        pov_chg_q;

  // sequencer
  seq_state_e  state_q, state_d;
  logic [4:0]  slot_q, slot_d;

  // held event, waiting to learn whether it is the last one
  logic        hold_vld_q;
  logic        hold_kind_q;
  logic [4:0]  hold_code_q;
  logic [15:0] hold_val_q;

  // output register
  logic        out_vld_q;
  logic        out_kind_q;
  logic [4:0]  out_code_q;
  logic [15:0] out_val_q;
  logic        out_last_q;

  // slot evaluation
  cmp_req_t    req;
  logic        unit_hit;
  logic        slot_en;
  logic        use_flag;
  logic        hit;
  logic        ev_kind;
  logic [4:0]  ev_code;
  logic [15:0] ev_val;
  logic [1:0]  ax_idx;
  logic        trg_idx;
  logic        hat_y;
  logic [15:0] raw_ax;
  logic [15:0] sv_ax;
  logic [15:0] dpad_hx;
  logic [15:0] dpad_hy;
  logic [31:0] pov_hat;
  logic [15:0] hat_cand;

  // handshake and control
  logic        out_free;
  logic        accept;
  logic        step;
  logic        push;
  logic        push_last;

  assign ax_idx  = slot_q[1:0];
  assign trg_idx = slot_q[0];
  assign hat_y   = slot_q[0];
  assign raw_ax  = smp_axis_q[ax_idx];
  assign sv_ax   = ax_idx[0] ? 16'(~raw_ax + 16'd1) : raw_ax;
  assign pov_hat = pov_to_hat(smp_pov_q);

  // d-pad to hat, down over up and right over left
  always_comb begin
    dpad_hx = '0;
    dpad_hy = '0;
    if (smp_btn_q[0]) dpad_hy = HatNeg;
    if (smp_btn_q[1]) dpad_hy = HatPos;
    if (smp_btn_q[2]) dpad_hx = HatNeg;
    if (smp_btn_q[3]) dpad_hx = HatPos;
  end

  assign hat_cand = smp_mode_q ? (hat_y ? pov_hat[15:0] : pov_hat[31:16])
                               : (hat_y ? dpad_hy : dpad_hx);

  // operands and event fields of the current slot
  always_comb begin
    req      = '0;
    slot_en  = 1'b1;
    use_flag = 1'b0;
    ev_kind  = KindAxis;
    ev_code  = '0;
    ev_val   = '0;
    if (slot_q < SlotAx0) begin
      slot_en  = slot_q < SlotBtnEnd;
      req.op_a = {16'b0, smp_btn_q[slot_q[3:0]]};
      req.op_b = {16'b0, smp_mode_q ? prev_ubtn_q[slot_q[3:0]]
                                    : prev_sbtn_q[slot_q[3:0]]};
      ev_kind  = KindButton;
      ev_code  = slot_q;
      ev_val   = {15'b0, smp_btn_q[slot_q[3:0]]};
    end else if (slot_q < SlotTrg0) begin
      req.thr = axis_db_q;
      ev_code = slot_q - SlotAx0;
      if (smp_mode_q) begin
        req.op_a = {1'b0, raw_ax};
        req.op_b = {1'b0, prev_uaxes_q[ax_idx]};
        ev_val   = raw_ax ^ AxisBias;
      end else begin
        req.op_a = {sv_ax[15], sv_ax};
        req.op_b = {prev_saxes_q[ax_idx][15], prev_saxes_q[ax_idx]};
        ev_val   = sv_ax;
      end
    end else if (slot_q < SlotHatX) begin
      slot_en  = !smp_mode_q;
      req.op_a = {9'b0, smp_trig_q[trg_idx]};
      req.op_b = {9'b0, prev_trig_q[trg_idx]};
      req.thr  = {8'b0, trig_db_q};
      ev_code  = CodeTrg0 + {4'b0, trg_idx};
      ev_val   = trig_scale(smp_trig_q[trg_idx]);
    end else begin
      ev_code = CodeHatX + {4'b0, hat_y};
      ev_val  = hat_cand;
      if (smp_mode_q) begin
        use_flag = hat_y;
        req.op_a = {1'b0, smp_pov_q};
        req.op_b = {1'b0, prev_pov_q};
      end else begin
        req.op_a = {hat_cand[15], hat_cand};
        req.op_b = {prev_hat_q[hat_y][15], prev_hat_q[hat_y]};
      end
    end
  end

  gcee_diff_unit u_diff (
    .req_i (req),
    .hit_o (unit_hit)
  );

  assign hit = slot_en && (use_flag ? pov_chg_q : unit_hit);

  // sequencer next state and strobes
  always_comb begin
    state_d   = state_q;
    slot_d    = slot_q;
    accept    = 1'b0;
    step      = 1'b0;
    push      = 1'b0;
    push_last = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          accept  = 1'b1;
          slot_d  = req_type_i ? SlotBtnFirstU : SlotBtnFirstS;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!(hit && hold_vld_q && !out_free)) begin
          step = 1'b1;
          push = hit && hold_vld_q;
          if (slot_q == SlotHatY) begin
            state_d = ST_FLUSH;
          end else begin
            slot_d = slot_q + 5'd1;
          end
        end
      end
      ST_FLUSH: begin
        if (!hold_vld_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          push      = 1'b1;
          push_last = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_free   = !out_vld_q || !out_stall_i;
  assign in_stall_o = state_q != ST_IDLE;

  // state and slot registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      slot_q  <= '0;
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_db_q <= AxisDbReset;
      trig_db_q <= TrigDbReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgAxisDb: axis_db_q <= cfg_wdata_i;
        CfgTrigDb: trig_db_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // sample latch
  always_ff @(posedge clk_i) begin
    if (accept) begin
      smp_mode_q    <= req_type_i;
      smp_btn_q     <= button_bits_i;
      smp_axis_q[0] <= stick_lx_i;
      smp_axis_q[1] <= stick_ly_i;
      smp_axis_q[2] <= stick_rx_i;
      smp_axis_q[3] <= stick_ry_i;
      smp_trig_q[0] <= trig_left_i;
      smp_trig_q[1] <= trig_right_i;
      smp_pov_q     <= pov_angle_i;
    end
  end

  // previous values, written as each slot completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_sbtn_q  <= '0;
      prev_ubtn_q  <= '0;
      prev_pov_q   <= PovCentre;
      pov_chg_q    <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        prev_saxes_q[i] <= '0;
        prev_uaxes_q[i] <= AxisBias;
      end
      for (int i = 0; i < 2; i++) begin
        prev_trig_q[i] <= '0;
        prev_hat_q[i]  <= '0;
      end
    end else if (step) begin
      if (slot_q == SlotBtnLast) begin
        if (smp_mode_q) begin
          prev_ubtn_q <= smp_btn_q;
        end else begin
          prev_sbtn_q <= smp_btn_q;
        end
      end
      if (slot_q >= SlotAx0 && slot_q < SlotTrg0 && hit) begin
        if (smp_mode_q) begin
          prev_uaxes_q[ax_idx] <= raw_ax;
        end else begin
          prev_saxes_q[ax_idx] <= sv_ax;
        end
      end
      if (slot_q >= SlotTrg0 && slot_q < SlotHatX && hit) begin
        prev_trig_q[trg_idx] <= smp_trig_q[trg_idx];
      end
      if (slot_q >= SlotHatX && hit && !smp_mode_q) begin
        prev_hat_q[hat_y] <= hat_cand;
      end
      if (slot_q == SlotHatX && smp_mode_q) begin
        pov_chg_q <= hit;
        if (hit) begin
          prev_pov_q <= smp_pov_q;
        end
      end
    end
  end

  // held event
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_vld_q <= 1'b0;
    end else if (step && hit) begin
      hold_vld_q <= 1'b1;
    end else if (push) begin
      hold_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && hit) begin
      hold_kind_q <= ev_kind;
      hold_code_q <= ev_code;
      hold_val_q  <= ev_val;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (push) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_kind_q <= hold_kind_q;
      out_code_q <= hold_code_q;
      out_val_q  <= hold_val_q;
      out_last_q <= push_last;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign event_kind_o  = out_kind_q;
  assign event_code_o  = out_code_q;
  assign event_value_o = $signed(out_val_q);
  assign last_event_o  = out_last_q;

  // checks
  `GCEE_ASSERT(a_idle_no_hold, (state_q == ST_IDLE) |-> !hold_vld_q, "event held while idle")
  `GCEE_ASSERT(a_slot_range, (state_q == ST_SCAN) |-> (slot_q <= SlotHatY), "scan slot out of range")
  `GCEE_ASSERT_NEXT(a_flush_last, (state_q == ST_FLUSH) && hold_vld_q && out_free,
                    out_vld_q && out_last_q && (state_q == ST_IDLE), "final event not released")
  `GCEE_ASSERT(a_push_room, push |-> out_free, "event pushed over a stalled output")

endmodule

`default_nettype wire

// ===== tb/sv/gamepad_change_event_encoder_top_test.sv =====
// self-checking testbench for gamepad_change_event_encoder_top
// depends on gcee_pkg and the encoder rtl; samples go in, change events are checked in order
`timescale 1ns / 1ps

module gamepad_change_event_encoder_top_test;
  import gcee_pkg::*;

  localparam int WatchdogLimit = 4000;
  localparam int HoldCycles    = 400;
  localparam int SettleCycles  = 64;

  // unused register slots, written to show they are ignored
  localparam logic [1:0] CfgSpare2 = 2'd2;
  localparam logic [1:0] CfgSpare3 = 2'd3;

  localparam logic [4:0] CodeHatY = CodeHatX + 5'd1;

  // d-pad bit positions in a signed-style button word
  localparam int DpadUp    = 0;
  localparam int DpadDown  = 1;
  localparam int DpadLeft  = 2;
  localparam int DpadRight = 3;

  // trigger scaling
  localparam int TrigFull = 32767;
  localparam int TrigTop  = 255;

  typedef struct packed {
    logic        req_type;
    logic [15:0] buttons;
    logic [15:0] lx;
    logic [15:0] ly;
    logic [15:0] rx;
    logic [15:0] ry;
    logic [7:0]  trig_l;
    logic [7:0]  trig_r;
    logic [15:0] pov;
  } gamepad_sample_t;

  typedef struct packed {
    logic        kind;
    logic [4:0]  code;
    logic [15:0] value;
    logic        last;
  } change_event_t;

  // dut connections
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b1;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_idx_i     = '0;
  logic [15:0] cfg_wdata_i   = '0;
  logic        in_valid_i    = 1'b0;
  logic        in_stall_o;
  logic        req_type_i    = 1'b0;
  logic [15:0] button_bits_i = '0;
  logic [15:0] stick_lx_i    = '0;
  logic [15:0] stick_ly_i    = '0;
  logic [15:0] stick_rx_i    = '0;
  logic [15:0] stick_ry_i    = '0;
  logic [7:0]  trig_left_i   = '0;
  logic [7:0]  trig_right_i  = '0;
  logic [15:0] pov_angle_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i   = 1'b0;
  logic        event_kind_o;
  logic [4:0]  event_code_o;
  logic signed [15:0] event_value_o;
  logic        last_event_o;

  // encoder state as the testbench sees it
  logic [15:0] axis_db     = AxisDbReset;
  logic [7:0]  trig_db     = TrigDbReset;
  logic [15:0] sgn_buttons = '0;
  logic [15:0] sgn_axes [4] = '{default: '0};
  logic [7:0]  sgn_trigs [2] = '{default: '0};
  logic [15:0] sgn_hat [2] = '{default: '0};
  logic [15:0] uns_buttons = '0;
  logic [15:0] uns_axes [4] = '{default: AxisBias};
  logic [15:0] uns_pov     = PovCentre;

  gamepad_sample_t samples_to_send [$];
  change_event_t   due_events [$];
  gamepad_sample_t offered;
  gamepad_sample_t roam_s = '0;
  gamepad_sample_t roam_u = '0;
  change_event_t   want;

  logic [15:0] pov_marks [15] = '{Pov45, Pov135, Pov225, Pov315, 16'd9000, 16'd18000,
                                  16'd27000, 16'd35999, 16'd36000, 16'd40000, 16'hFFFE,
                                  PovCentre, PovCentre, Pov45 - 16'd1, Pov45 + 16'd1};

  bit idling_on  = 1'b1;
  bit hold_armed = 1'b0;
  bit hold_done  = 1'b0;
  int send_gap    = 0;
  int stall_left  = 0;
  int hold_left   = 0;
  int quiet_cycles = 0;
  int mismatch_count = 0;
  int events_seen = 0;

  gamepad_change_event_encoder_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .button_bits_i (button_bits_i),
    .stick_lx_i    (stick_lx_i),
    .stick_ly_i    (stick_ly_i),
    .stick_rx_i    (stick_rx_i),
    .stick_ry_i    (stick_ry_i),
    .trig_left_i   (trig_left_i),
    .trig_right_i  (trig_right_i),
    .pov_angle_i   (pov_angle_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .event_kind_o  (event_kind_o),
    .event_code_o  (event_code_o),
    .event_value_o (event_value_o),
    .last_event_o  (last_event_o)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    $display("mismatch @%0t: %s", $time, what);
  endtask

  function automatic int level_gap(input int a, input int b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic change_event_t make_event(input logic kind, input logic [4:0] code,
                                               input logic [15:0] value);
    change_event_t e;
    e.kind  = kind;
    e.code  = code;
    e.value = value;
    e.last  = 1'b0;
    return e;
  endfunction

  // events caused by one sample, in output order; updates the held previous values
  function automatic void encode_sample(input gamepad_sample_t s);
    change_event_t evs [$];
    change_event_t e;
    logic [15:0] axes_raw [4];
    logic [15:0] changed;
    logic signed [15:0] v;
    logic [15:0] hx;
    logic [15:0] hy;
    int lv;
    axes_raw = '{s.lx, s.ly, s.rx, s.ry};
    hx = '0;
    hy = '0;
    if (!s.req_type) begin
      // buttons above the d-pad
      changed = s.buttons ^ sgn_buttons;
      for (int i = int'(SlotBtnFirstS); i < BtnLimit; i++) begin
        if (changed[i]) evs.push_back(make_event(KindButton, 5'(i), {15'd0, s.buttons[i]}));
      end
      sgn_buttons = s.buttons;
      // sticks, y negated with wrap
      for (int a = 0; a < 4; a++) begin
        v = axes_raw[a];
        if (a % 2 == 1) v = -v;
        if (level_gap(int'(v), int'($signed(sgn_axes[a]))) > int'(axis_db)) begin
          evs.push_back(make_event(KindAxis, 5'(a), v));
          sgn_axes[a] = v;
        end
      end
      // triggers
      for (int t = 0; t < 2; t++) begin
        lv = (t == 0) ? int'(s.trig_l) : int'(s.trig_r);
        if (level_gap(lv, int'(sgn_trigs[t])) > int'(trig_db)) begin
          evs.push_back(make_event(KindAxis, CodeTrg0 + 5'(t), 16'((lv * TrigFull) / TrigTop)));
          sgn_trigs[t] = 8'(lv);
        end
      end
      // d-pad to hat, down beats up and right beats left
      if (s.buttons[DpadUp])    hy = HatNeg;
      if (s.buttons[DpadDown])  hy = HatPos;
      if (s.buttons[DpadLeft])  hx = HatNeg;
      if (s.buttons[DpadRight]) hx = HatPos;
      if (hx != sgn_hat[0]) begin
        evs.push_back(make_event(KindAxis, CodeHatX, hx));
        sgn_hat[0] = hx;
      end
      if (hy != sgn_hat[1]) begin
        evs.push_back(make_event(KindAxis, CodeHatY, hy));
        sgn_hat[1] = hy;
      end
    end else begin
      changed = s.buttons ^ uns_buttons;
      for (int i = int'(SlotBtnFirstU); i < BtnLimit; i++) begin
        if (changed[i]) evs.push_back(make_event(KindButton, 5'(i), {15'd0, s.buttons[i]}));
      end
      uns_buttons = s.buttons;
      // unsigned sticks, reported around the bias
      for (int a = 0; a < 4; a++) begin
        if (level_gap(int'(axes_raw[a]), int'(uns_axes[a])) > int'(axis_db)) begin
          evs.push_back(make_event(KindAxis, 5'(a), axes_raw[a] ^ AxisBias));
          uns_axes[a] = axes_raw[a];
        end
      end
      // any pov change reports both hat axes
      if (s.pov != uns_pov) begin
        if (s.pov != PovCentre) begin
          if (s.pov >= Pov315 || s.pov <= Pov45) hy = HatNeg;
          else if (s.pov >= Pov135 && s.pov <= Pov225) hy = HatPos;
          if (s.pov >= Pov45 && s.pov <= Pov135) hx = HatPos;
          else if (s.pov >= Pov225 && s.pov <= Pov315) hx = HatNeg;
        end
        evs.push_back(make_event(KindAxis, CodeHatX, hx));
        evs.push_back(make_event(KindAxis, CodeHatY, hy));
        uns_pov = s.pov;
      end
    end
    foreach (evs[k]) begin
      e = evs[k];
      e.last = (k == evs.size() - 1);
      due_events.push_back(e);
    end
  endfunction

  function automatic gamepad_sample_t make_sample(
    input logic mode, input logic [15:0] buttons, input logic [15:0] lx, input logic [15:0] ly,
    input logic [15:0] rx, input logic [15:0] ry, input logic [7:0] tl, input logic [7:0] tr,
    input logic [15:0] pov);
    gamepad_sample_t s;
    s.req_type = mode;
    s.buttons  = buttons;
    s.lx       = lx;
    s.ly       = ly;
    s.rx       = rx;
    s.ry       = ry;
    s.trig_l   = tl;
    s.trig_r   = tr;
    s.pov      = pov;
    return s;
  endfunction

  // stick drift of random reach, from a few counts to a large swing
  function automatic logic [15:0] nudge16(input logic [15:0] x);
    int span;
    span = 64 << (2 * int'($urandom_range(0, 4)));
    return 16'(int'(x) + int'($urandom_range(0, 2 * span)) - span);
  endfunction

  // next sample of a drifting pad; now and then a repeat or a wholly random sample
  function automatic gamepad_sample_t roam_sample();
    gamepad_sample_t s;
    logic mode;
    int pick;
    mode = 1'($urandom_range(0, 1));
    s = mode ? roam_u : roam_s;
    pick = $urandom_range(0, 11);
    if (pick == 0) begin
      s.buttons = 16'($urandom);
      s.lx      = 16'($urandom);
      s.ly      = 16'($urandom);
      s.rx      = 16'($urandom);
      s.ry      = 16'($urandom);
      s.trig_l  = 8'($urandom);
      s.trig_r  = 8'($urandom);
      s.pov     = 16'($urandom);
    end else if (pick > 1) begin
      repeat ($urandom_range(0, 3)) s.buttons[$urandom_range(0, 15)] ^= 1'b1;
      s.lx     = nudge16(s.lx);
      s.ly     = nudge16(s.ly);
      s.rx     = nudge16(s.rx);
      s.ry     = nudge16(s.ry);
      s.trig_l = 8'(int'(s.trig_l) + int'($urandom_range(0, 40)) - 20);
      s.trig_r = 8'(int'(s.trig_r) + int'($urandom_range(0, 40)) - 20);
      case ($urandom_range(0, 3))
        0: s.pov = pov_marks[$urandom_range(0, 14)];
        1: s.pov = 16'($urandom_range(0, 35999));
        2: s.pov = 16'($urandom);
        default: ;
      endcase
    end
    s.req_type = mode;
    if (mode) roam_u = s;
    else roam_s = s;
    return s;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      CfgAxisDb: axis_db = data;
      CfgTrigDb: trig_db = data[7:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic queue_roaming(input int count);
    repeat (count) samples_to_send.push_back(roam_sample());
  endtask

  // wait for every request to go in and every event to come out, then let a silent scan end
  task automatic drain_and_settle();
    while (samples_to_send.size() != 0 || in_valid_i || due_events.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // sample driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) encode_sample(offered);
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (samples_to_send.size() > 0) begin
          offered = samples_to_send.pop_front();
          in_valid_i    <= 1'b1;
          req_type_i    <= offered.req_type;
          button_bits_i <= offered.buttons;
          stick_lx_i    <= offered.lx;
          stick_ly_i    <= offered.ly;
          stick_rx_i    <= offered.rx;
          stick_ry_i    <= offered.ry;
          trig_left_i   <= offered.trig_l;
          trig_right_i  <= offered.trig_r;
          pov_angle_i   <= offered.pov;
          if (idling_on && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 13);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // event monitor and receiver stalls
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        events_seen++;
        if (due_events.size() == 0) begin
          flag_mismatch($sformatf("event %0d with nothing due: kind %0d code %0d value %0d",
                                  events_seen, event_kind_o, event_code_o, event_value_o));
        end else begin
          want = due_events.pop_front();
          if (event_kind_o !== want.kind)
            flag_mismatch($sformatf("event %0d kind %0d, expected %0d",
                                    events_seen, event_kind_o, want.kind));
          if (event_code_o !== want.code)
            flag_mismatch($sformatf("event %0d code %0d, expected %0d",
                                    events_seen, event_code_o, want.code));
          if (event_value_o !== want.value)
            flag_mismatch($sformatf("event %0d value %0d, expected %0d",
                                    events_seen, event_value_o, $signed(want.value)));
          if (last_event_o !== want.last)
            flag_mismatch($sformatf("event %0d last flag %0d, expected %0d",
                                    events_seen, last_event_o, want.last));
        end
      end
      // one long hold-off so the encoder backs up into its input
      if (hold_armed && !hold_done && out_valid_o) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (idling_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 12);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // watchdog on cycles with no request moving on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("no request moved for %0d cycles, %0d events still due",
                 quiet_cycles, due_events.size());
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // stimulus phases
  initial begin
    #1 rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed samples at the reset deadbands
    samples_to_send.push_back(make_sample(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                          16'h0000, 8'h00, 8'h00, 16'h0000));
    // every signed-style report at once, -32768 on a y axis
    samples_to_send.push_back(make_sample(1'b0, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h8000,
                                          16'h7FFF, 8'hFF, 8'hFF, 16'h0000));
    // changes exactly at the deadbands, the right trigger one count past, up and left on the d-pad
    samples_to_send.push_back(make_sample(1'b0, 16'h0005, 16'h7CDF, 16'h8000, 16'h8320,
                                          16'h7FFF, 8'hF5, 8'hF4, 16'h0000));
    // one count past the deadband, up and down together
    samples_to_send.push_back(make_sample(1'b0, 16'h0003, 16'h7CDE, 16'h0000, 16'h0000,
                                          16'h8000, 8'h00, 8'h00, 16'hFFFF));
    // left and right together
    samples_to_send.push_back(make_sample(1'b0, 16'h000C, 16'h7CDE, 16'h0000, 16'h0000,
                                          16'h8000, 8'h00, 8'h00, 16'hFFFF));
    // unsigned-style floor, then every unsigned-style report at once
    samples_to_send.push_back(make_sample(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                          16'h0000, 8'h00, 8'h00, PovCentre));
    samples_to_send.push_back(make_sample(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                          16'hFFFF, 8'hFF, 8'hFF, 16'h0000));
    // pov boundaries, out-of-range angles, centring and a repeat
    foreach (pov_marks[k]) begin
      samples_to_send.push_back(make_sample(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                            16'hFFFF, 8'h00, 8'h00, pov_marks[k]));
    end
    samples_to_send.push_back(make_sample(1'b1, 16'h8001, AxisBias, AxisBias, AxisBias,
                                          AxisBias, 8'h00, 8'h00, Pov45));
    drain_and_settle();

    // zero deadbands, with the long receiver hold-off
    write_reg(CfgAxisDb, 16'h0000);
    write_reg(CfgTrigDb, 16'h0000);
    hold_armed = 1'b1;
    queue_roaming(60);
    drain_and_settle();

    // widest deadbands; spare register indexes change nothing
    write_reg(CfgAxisDb, 16'hFFFF);
    write_reg(CfgTrigDb, 16'h00FF);
    write_reg(CfgSpare3, 16'h0000);
    queue_roaming(40);
    drain_and_settle();

    // random deadbands; upper bits of a trigger write are dropped
    repeat (2) begin
      write_reg(CfgAxisDb, 16'($urandom_range(1, 3000)));
      write_reg(CfgTrigDb, 16'h0100 | 16'($urandom_range(1, 40)));
      write_reg(CfgSpare2, 16'($urandom));
      queue_roaming(40);
      drain_and_settle();
    end

    // back to the reset deadbands, both sides at full rate
    write_reg(CfgAxisDb, AxisDbReset);
    write_reg(CfgTrigDb, {8'h00, TrigDbReset});
    idling_on = 1'b0;
    queue_roaming(70);
    drain_and_settle();

    if (due_events.size() != 0) begin
      flag_mismatch($sformatf("%0d expected events never arrived", due_events.size()));
    end
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/gcee_pkg.sv
hw/rtl/gcee_diff_unit.sv
hw/rtl/gamepad_change_event_encoder_top.sv
tb/sv/gamepad_change_event_encoder_top_test.sv
